// File: sv/assert_macros.svh
// Assertion macros for the RTL of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must never be true, disabled while reset is asserted.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// File: sv/spq_pkg.sv
// Shared constants, types and codes of the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int PAY_W  = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // run compare-and-shift on the captured word
    } dp_cmd_t;

endpackage

// File: sv/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output spq_pkg::dp_cmd_t  dp_cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == spq_pkg::ST_EXEC);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = spq_pkg::ST_EXEC;
                end
            end
            spq_pkg::ST_EXEC:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b0;
        dp_cmd.load = 1'b0;
        dp_cmd.exec = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                dp_cmd.load = start;
            end
            spq_pkg::ST_EXEC:
            begin
                busy        = 1'b1;
                dp_cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// File: sv/spq_datapath.sv
// Datapath: sorted entry registers with per-entry compare-and-shift.
module spq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_pkg::dp_cmd_t             dp_cmd,
    input  logic                         cmd,
    input  logic signed [spq_pkg::KEY_W-1:0]  in_key,
    input  logic [spq_pkg::DATA_W-1:0]   in_payload,
    output spq_pkg::status_t             res_status,
    output logic signed [spq_pkg::KEY_W-1:0]  res_key,
    output logic [spq_pkg::DATA_W-1:0]   res_payload,
    output logic [spq_pkg::OCC_W-1:0]    res_occupancy
);

    localparam int CAP = spq_pkg::CAPACITY;

    // Captured word
    spq_pkg::cmd_t                      cmd_reg;
    logic signed [spq_pkg::KEY_W-1:0]   key_reg;
    logic [spq_pkg::PAY_W-1:0]          pay_reg;

    // Entry registers, front at index 0
    logic signed [spq_pkg::KEY_W-1:0]   key_cell_reg  [CAP];
    logic signed [spq_pkg::KEY_W-1:0]   key_cell_next [CAP];
    logic [spq_pkg::PAY_W-1:0]          pay_cell_reg  [CAP];
    logic [spq_pkg::PAY_W-1:0]          pay_cell_next [CAP];

    logic [spq_pkg::CNT_W-1:0]          count_reg;
    logic [spq_pkg::CNT_W-1:0]          count_next;

    spq_pkg::status_t                   status_reg;
    spq_pkg::status_t                   status_next;
    logic signed [spq_pkg::KEY_W-1:0]   okey_reg;
    logic signed [spq_pkg::KEY_W-1:0]   okey_next;
    logic [spq_pkg::PAY_W-1:0]          opay_reg;
    logic [spq_pkg::PAY_W-1:0]          opay_next;

    logic                               full;
    logic                               empty;
    logic [CAP-1:0]                     after_vec;

    assign full  = (count_reg == spq_pkg::CNT_W'(CAP));
    assign empty = (count_reg == '0);

    // An entry stays in place when the new key goes behind it; the front
    // entry decides alone whether the new key may pass any entry at all.
    always_comb
    begin
        after_vec    = '0;
        after_vec[0] = !empty && (key_cell_reg[0] < key_reg);
        for (int i = 1; i < CAP; i++)
        begin
            after_vec[i] = after_vec[0] && (spq_pkg::CNT_W'(i) < count_reg)
                           && (key_cell_reg[i] <= key_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            key_cell_next[i] = key_cell_reg[i];
            pay_cell_next[i] = pay_cell_reg[i];
        end
        count_next  = count_reg;
        status_next = status_reg;
        okey_next   = okey_reg;
        opay_next   = opay_reg;

        if (dp_cmd.exec)
        begin
            okey_next   = '0;
            opay_next   = '0;
            status_next = spq_pkg::STATUS_DONE;
            case (cmd_reg)
                spq_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = spq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        if (!after_vec[0])
                        begin
                            key_cell_next[0] = key_reg;
                            pay_cell_next[0] = pay_reg;
                        end
                        for (int i = 1; i < CAP; i++)
                        begin
                            if (!after_vec[i])
                            begin
                                if (after_vec[i-1])
                                begin
                                    key_cell_next[i] = key_reg;
                                    pay_cell_next[i] = pay_reg;
                                end
                                else
                                begin
                                    key_cell_next[i] = key_cell_reg[i-1];
                                    pay_cell_next[i] = pay_cell_reg[i-1];
                                end
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        status_next = spq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        okey_next = key_cell_reg[0];
                        opay_next = pay_cell_reg[0];
                        for (int i = 0; i < CAP - 1; i++)
                        begin
                            key_cell_next[i] = key_cell_reg[i+1];
                            pay_cell_next[i] = pay_cell_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= spq_pkg::STATUS_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg <= spq_pkg::cmd_t'(cmd);
            key_reg <= in_key;
            pay_reg <= spq_pkg::PAY_W'(in_payload);
        end
        for (int i = 0; i < CAP; i++)
        begin
            key_cell_reg[i] <= key_cell_next[i];
            pay_cell_reg[i] <= pay_cell_next[i];
        end
        okey_reg <= okey_next;
        opay_reg <= opay_next;
    end

    assign res_status    = status_reg;
    assign res_key       = okey_reg;
    assign res_payload   = spq_pkg::DATA_W'(opay_reg);
    assign res_occupancy = spq_pkg::OCC_W'(count_reg);

endmodule

// File: sv/sorted_priority_queue_core.sv
// An accepted word is captured; result and done are registered when the execute cycle ends.
// No word is accepted while busy; busy is high for the one execute cycle after acceptance.
// The execute cycle compares the new key against every entry at once and shifts in place.
// Results show for one cycle under done; the receiver cannot stall, so nothing is held back.
// Reset (rst_n low, asynchronous) empties the queue and returns the controller to idle.
`include "assert_macros.svh"

module sorted_priority_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic                              cmd,
    input  logic signed [spq_pkg::KEY_W-1:0]  in_key,
    input  logic [spq_pkg::DATA_W-1:0]        in_payload,
    output logic [1:0]                        status,
    output logic signed [spq_pkg::KEY_W-1:0]  out_key,
    output logic [spq_pkg::DATA_W-1:0]        out_payload,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    spq_pkg::dp_cmd_t  dp_cmd;
    spq_pkg::status_t  res_status;

    // Sequencer: idle until start, then the execute state, then strobe done.
    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .dp_cmd (dp_cmd)
    );

    // Entry registers, compare-and-shift logic, entry count and result word.
    spq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .cmd           (cmd),
        .in_key        (in_key),
        .in_payload    (in_payload),
        .res_status    (res_status),
        .res_key       (out_key),
        .res_payload   (out_payload),
        .res_occupancy (occupancy)
    );

    // Present the status code on the plain port.
    assign status = res_status;

    // An accepted word always yields its result strobe on done.
    `ASSERT_CLK(a_result_follows, clk, rst_n, (start && !busy) |-> ##2 done, "missing result strobe")

    // The controller is back in idle whenever a result is shown.
    `ASSERT_NEVER(a_done_while_busy, clk, rst_n, done && busy, "result shown while busy")

    // A rejected insert leaves the queue at full capacity.
    `ASSERT_CLK(a_full_occ, clk, rst_n, (done && status == spq_pkg::STATUS_FULL) |-> (occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY)), "full status with wrong occupancy")

    // A failed insert or remove returns a zero word.
    `ASSERT_CLK(a_zero_word, clk, rst_n, (done && status != spq_pkg::STATUS_DONE) |-> (out_key == '0 && out_payload == '0), "failed operation returned data")

endmodule

// File: verif/spq_order_checker.sv
// Predicts each queue operation and checks the result words of the priority queue.
module spq_order_checker
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     done,
    input  logic                     cmd,
    input  logic signed [KEY_W-1:0]  in_key,
    input  logic [DATA_W-1:0]        in_payload,
    input  logic [1:0]               status,
    input  logic signed [KEY_W-1:0]  out_key,
    input  logic [DATA_W-1:0]        out_payload,
    input  logic [OCC_W-1:0]         occupancy,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_W-1:0] PAYLOAD_KEEP = {DATA_W{1'b1}} >> (DATA_W - PAY_W);

    typedef struct {
        status_t                 status;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       payload;
        logic [OCC_W-1:0]        occupancy;
    } queue_outcome_t;

    // Shadow copy of the sorted entries, front at index 0.
    logic signed [KEY_W-1:0] shadow_key [CAPACITY+1];
    logic [DATA_W-1:0]       shadow_payload [CAPACITY+1];
    int                      shadow_count;

    queue_outcome_t awaited_outcomes [$];

    // Apply one operation to the shadow queue and return the word it must produce.
    function automatic queue_outcome_t compute_queue_result(
        input cmd_t                    op,
        input logic signed [KEY_W-1:0] key,
        input logic [DATA_W-1:0]       payload
    );
        queue_outcome_t outcome;
        int             pos;
        outcome.status  = STATUS_DONE;
        outcome.key     = '0;
        outcome.payload = '0;
        if (op == CMD_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                outcome.status = STATUS_FULL;
            else
            begin
                // A key at or below the front goes ahead of it; otherwise behind equal keys.
                pos = 0;
                if (shadow_count != 0 && key > shadow_key[0])
                begin
                    pos = 1;
                    while (pos < shadow_count && shadow_key[pos] <= key)
                        pos++;
                end
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_key[i]     = shadow_key[i-1];
                    shadow_payload[i] = shadow_payload[i-1];
                end
                shadow_key[pos]     = key;
                shadow_payload[pos] = payload & PAYLOAD_KEEP;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                outcome.status = STATUS_EMPTY;
            else
            begin
                outcome.key     = shadow_key[0];
                outcome.payload = shadow_payload[0];
                for (int i = 0; i < shadow_count - 1; i++)
                begin
                    shadow_key[i]     = shadow_key[i+1];
                    shadow_payload[i] = shadow_payload[i+1];
                end
                shadow_count--;
            end
        end
        outcome.occupancy = OCC_W'(shadow_count);
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        queue_outcome_t want;
        int             fails;
        if (!rst_n)
        begin
            shadow_count = 0;
            awaited_outcomes.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            fails = 0;
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result word with no operation outstanding");
                    fails++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                    if (out_key !== want.key)
                    begin
                        $error("out_key: expected %0d, got %0d", want.key, out_key);
                        fails++;
                    end
                    if (out_payload !== want.payload)
                    begin
                        $error("out_payload: expected %0h, got %0h", want.payload, out_payload);
                        fails++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                awaited_outcomes.push_back(compute_queue_result(cmd_t'(cmd), in_key, in_payload));
            mismatches  <= mismatches + fails;
            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

// File: verif/sorted_priority_queue_core_test.sv
// Top of the priority queue test: clock, reset, operation stimulus, watchdog and verdict.
module sorted_priority_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Allow far more than the slowest legal spacing between handshakes, the largest gap plus
    // the operation, before calling the block hung.
    localparam int STALL_LIMIT  = 200;
    localparam int RANDOM_WORDS = 1100;

    typedef enum {FILL_UP, DRAIN_DOWN, MIXED} phase_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    done;
    logic                    cmd;
    logic signed [KEY_W-1:0] in_key;
    logic [DATA_W-1:0]       in_payload;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [DATA_W-1:0]       out_payload;
    logic [OCC_W-1:0]        occupancy;
    int                      mismatches;
    int                      outstanding;
    int                      quiet_cycles;

    // Opening fill: extremes, a tie with the front, a tie in the middle, a tie at the back.
    logic [31:0] opening_keys [16] = '{
        32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
        32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0005,
        32'h0000_0005, 32'hffff_fff9, 32'h0000_0064, 32'hffff_ff9c,
        32'h0000_000c, 32'h0000_0003, 32'h0000_0003, 32'h0000_0002
    };

    sorted_priority_queue_core dut (.*);

    spq_order_checker order_check (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hold off or drive one word, then wait for the edge that takes it.
    // Return at the accepting edge so the next word can follow back to back.
    task automatic issue_word(
        input cmd_t        op,
        input logic [31:0] key,
        input logic [31:0] payload,
        input int          gap
    );
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        in_key     <= key;
        in_payload <= payload;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mix clustered keys (to force ties), fully random keys and the extremes.
    function automatic logic [31:0] draw_key();
        case ($urandom_range(4))
            0: return $urandom_range(8) - 4;
            1, 2: return $urandom;
            3: return 32'h8000_0000 + $urandom_range(3);
            default:
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
        endcase
    endfunction

    initial
    begin
        phase_t mode;
        int     sent;
        int     span;
        bit     gappy;
        int     insert_pct;
        cmd_t   op;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_INSERT;
        in_key     = '0;
        in_payload = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: remove on an empty queue, fill to capacity, reject one
        // insert when full, then drain part of the way.
        issue_word(CMD_REMOVE, draw_key(), $urandom, $urandom_range(6));
        for (int i = 0; i < 16; i++)
            issue_word(CMD_INSERT, opening_keys[i],
                       (i == 1) ? 32'hffff_ffff : (i == 0) ? 32'h0 : 32'hc0de_0000 + i,
                       $urandom_range(6));
        issue_word(CMD_INSERT, 32'h8000_0000, 32'hffff_ffff, $urandom_range(6));
        repeat (6)
            issue_word(CMD_REMOVE, draw_key(), $urandom, $urandom_range(6));

        // Random part: phases that lean toward filling, draining or neither, so the
        // queue swings between empty and full; some phases run without any gaps.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            mode  = phase_t'($urandom_range(2));
            span  = $urandom_range(20, 80);
            gappy = ($urandom_range(3) != 0);
            case (mode)
                FILL_UP:    insert_pct = 85;
                DRAIN_DOWN: insert_pct = 15;
                default:    insert_pct = 50;
            endcase
            for (int i = 0; i < span && sent < RANDOM_WORDS; i++)
            begin
                op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
                issue_word(op, draw_key(), $urandom, gappy ? $urandom_range(6) : 0);
                sent++;
            end
        end
        start <= 1'b0;

        // Drain: wait for every predicted word, then keep watching for stray results before the verdict.
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS sorted_priority_queue_core");
        else
            $display("FAIL sorted_priority_queue_core");
        $finish;
    end

    // Watchdog: count cycles in which neither an operation nor a result is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sorted_priority_queue_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
